FILE: src/es_pkg.sv
// shared types and constants for the exchange sort engine
package es_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_ASET,
        ST_SCAN,
        ST_WRBACK,
        ST_EMIT
    } es_state_t;

    // one result beat handed from the sequencer to the output register
    typedef struct packed {
        logic   load;
        value_t value;
        logic   last;
        logic   ovf;
    } es_load_t;

endpackage

FILE: src/es_if.sv
// valid/ready stream interfaces for the element and result channels
interface es_in_if import es_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t value_in;
    logic   last_in;

    modport source (output valid, output value_in, output last_in, input ready);
    modport sink (input valid, input value_in, input last_in, output ready);
    modport monitor (input valid, input value_in, input last_in, input ready);
endinterface

interface es_out_if import es_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t value_out;
    logic   last_out;
    logic   overflowed;

    modport source (output valid, output value_out, output last_out, output overflowed,
                    input ready);
    modport sink (input valid, input value_out, input last_out, input overflowed,
                  output ready);
    modport monitor (input valid, input value_out, input last_out, input overflowed,
                     input ready);
endinterface

FILE: src/es_ram.sv
// generic simple dual-port ram with registered read
module es_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/es_seq.sv
// fill, exchange sort and readout sequencer around the element store
module es_seq import es_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = 64,
    localparam int unsigned AW = $clog2(MAX_ELEMENTS),
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  value_t        in_value,
    input  logic          in_last,
    input  logic          can_load,
    output es_load_t      load,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output value_t        ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  value_t        ram_rdata
);

    es_state_t     state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [AW-1:0] ocnt_reg, ocnt_next;
    logic          pend_reg, pend_next;
    value_t        a_reg, a_next;

    logic          accept;
    logic          room;
    logic [CW-1:0] fill_after;
    logic          swap;
    logic          last_cmp;
    logic          outer_done;
    logic          issue;
    logic          take;
    logic          load_last;

    assign in_ready   = (state_reg == ST_COLLECT);
    assign accept     = in_valid && in_ready;
    assign room       = fill_reg < CW'(MAX_ELEMENTS);
    assign fill_after = room ? fill_reg + CW'(1) : fill_reg;
    assign swap       = a_reg > ram_rdata;
    assign last_cmp   = (CW'(j_reg) + CW'(1)) == fill_reg;
    assign outer_done = (CW'(i_reg) + CW'(2)) == fill_reg;
    assign issue      = (k_reg < fill_reg) && (!pend_reg || can_load);
    assign take       = (state_reg == ST_EMIT) && pend_reg && can_load;
    assign load_last  = (CW'(ocnt_reg) + CW'(1)) == fill_reg;

    assign load.load  = take;
    assign load.value = ram_rdata;
    assign load.last  = load_last;
    assign load.ovf   = ovf_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (accept && in_last)
                begin
                    state_next = (fill_after >= CW'(2)) ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD:   state_next = ST_ASET;
            ST_ASET:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (last_cmp)
                begin
                    state_next = ST_WRBACK;
                end
            end
            ST_WRBACK: state_next = outer_done ? ST_EMIT : ST_ASET;
            ST_EMIT:
            begin
                if (take && load_last)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:   state_next = ST_COLLECT;
        endcase
    end

    // store accesses and datapath
    always_comb
    begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = '0;
        ocnt_next = '0;
        pend_next = 1'b0;
        a_next    = a_reg;
        ram_we    = 1'b0;
        ram_waddr = fill_reg[AW-1:0];
        ram_wdata = in_value;
        ram_re    = 1'b0;
        ram_raddr = i_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                i_next = '0;
                if (accept)
                begin
                    ram_we    = room;
                    fill_next = fill_after;
                    if (!room)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                ram_re = 1'b1;
            end
            ST_ASET:
            begin
                a_next    = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = i_reg + AW'(1);
                j_next    = i_reg + AW'(1);
            end
            ST_SCAN:
            begin
                ram_we    = swap;
                ram_waddr = j_reg;
                ram_wdata = a_reg;
                if (swap)
                begin
                    a_next = ram_rdata;
                end
                ram_re    = 1'b1;
                ram_raddr = j_reg + AW'(1);
                j_next    = j_reg + AW'(1);
            end
            ST_WRBACK:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = a_reg;
                ram_re    = 1'b1;
                ram_raddr = i_reg + AW'(1);
                i_next    = i_reg + AW'(1);
            end
            ST_EMIT:
            begin
                ram_re    = issue;
                ram_raddr = k_reg[AW-1:0];
                k_next    = issue ? k_reg + CW'(1) : k_reg;
                pend_next = issue || (pend_reg && !can_load);
                ocnt_next = take ? ocnt_reg + AW'(1) : ocnt_reg;
                if (take && load_last)
                begin
                    fill_next = '0;
                    ovf_next  = 1'b0;
                end
            end
            default:
            begin
                fill_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            ocnt_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            ocnt_reg  <= ocnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
    end

endmodule

FILE: src/es_out_stage.sv
// output register holding one result beat until the sink takes it
module es_out_stage import es_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  es_load_t load,
    output logic     can_load,
    es_out_if.source sorted
);

    logic   valid_reg, valid_next;
    value_t value_reg;
    logic   last_reg;
    logic   ovf_reg;

    assign can_load   = !valid_reg || sorted.ready;
    assign valid_next = load.load || (valid_reg && !sorted.ready);

    assign sorted.valid      = valid_reg;
    assign sorted.value_out  = value_reg;
    assign sorted.last_out   = last_reg;
    assign sorted.overflowed = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            value_reg <= load.value;
            last_reg  <= load.last;
            ovf_reg   <= load.ovf;
        end
    end

endmodule

FILE: src/exchange_sort_engine.sv
// top level of the exchange sort engine
//
//   channel    dir   payload                                 beat taken when
//   elements   in    value_in, last_in                       valid && ready
//   sorted     out   value_out, last_out, overflowed         valid && ready
//
// one element beat per cycle while collecting; ready is low from the last
// element until the final result has been loaded into the output register
// sorting a set makes one compare per cycle while scanning,
// bounded by the single read port of the element store
// readout gives one result per cycle when the sink keeps ready high
// the output register lets the final result wait while the next set is collected
// reset clears the fill count and overflow flag; the store itself is not cleared
module exchange_sort_engine import es_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    es_in_if.sink  elements,
    es_out_if.source sorted
);

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);

    es_load_t      load;
    logic          can_load;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    value_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    value_t        ram_rdata;

    es_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    es_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (elements.valid),
        .in_ready  (elements.ready),
        .in_value  (elements.value_in),
        .in_last   (elements.last_in),
        .can_load  (can_load),
        .load      (load),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    es_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .can_load (can_load),
        .sorted   (sorted)
    );

endmodule

FILE: src/es_checker.sv
// port-level checks on the element and sorted result streams, bound to the top level
module es_checker import es_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   in_last,
    input logic   out_valid,
    input logic   out_ready,
    input value_t out_value,
    input logic   out_last,
    input logic   out_ovf
);

    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

    logic          beat;
    logic          in_run_reg;
    value_t        prev_val_reg;
    logic          prev_ovf_reg;
    logic [CW-1:0] run_cnt_reg;

    assign beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg  <= 1'b0;
            run_cnt_reg <= '0;
        end
        else if (beat)
        begin
            in_run_reg  <= !out_last;
            run_cnt_reg <= out_last ? '0 : run_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            prev_val_reg <= out_value;
            prev_ovf_reg <= out_ovf;
        end
    end

    // results of one run come out in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        beat && in_run_reg |-> out_value >= prev_val_reg)
        else $error("sorted run not ascending");

    // overflow flag is the same on every result of a run
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        beat && in_run_reg |-> out_ovf == prev_ovf_reg)
        else $error("overflow flag changed within a run");

    // a run never exceeds the store depth
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        beat |-> run_cnt_reg < CW'(MAX_ELEMENTS))
        else $error("run longer than store depth");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_value) && $stable(out_last))
        else $error("stalled result beat changed");

    // no element is taken straight after the last one of a set
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("element taken while sorting");

endmodule

bind exchange_sort_engine es_checker #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_es_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (elements.valid),
    .in_ready  (elements.ready),
    .in_last   (elements.last_in),
    .out_valid (sorted.valid),
    .out_ready (sorted.ready),
    .out_value (sorted.value_out),
    .out_last  (sorted.last_out),
    .out_ovf   (sorted.overflowed)
);

FILE: tb/es_sort_checker.sv
// checker for the exchange sort engine: predicts each sorted run and compares result beats
module es_sort_checker import es_pkg::*; #(
    parameter int unsigned DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    es_in_if.monitor   elements,
    es_out_if.monitor  sorted,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        value_t value;
        logic   last;
        logic   ovf;
    } sorted_beat_t;

    value_t         collected [DEPTH];
    int unsigned    fill;
    logic           dropped;
    sorted_beat_t   ascending_q [$];

    always @(posedge clk or negedge rst_n)
    begin : track
        sorted_beat_t want;
        value_t       swap_tmp;
        if (!rst_n)
        begin
            fill = 0;
            dropped = 1'b0;
            ascending_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (sorted.valid && sorted.ready)
            begin
                if (ascending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sorted beat: value %0d last %0b ovf %0b",
                                 sorted.value_out, sorted.last_out, sorted.overflowed);
                end
                else
                begin
                    want = ascending_q.pop_front();
                    if (sorted.value_out !== want.value || sorted.last_out !== want.last ||
                        sorted.overflowed !== want.ovf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"sorted beat mismatch: expected value %0d last %0b ovf %0b,",
                                      " got value %0d last %0b ovf %0b"},
                                     want.value, want.last, want.ovf,
                                     sorted.value_out, sorted.last_out, sorted.overflowed);
                    end
                end
            end
            if (elements.valid && elements.ready)
            begin
                if (fill < DEPTH)
                begin
                    collected[fill] = elements.value_in;
                    fill++;
                end
                else
                    dropped = 1'b1;
                if (elements.last_in)
                begin
                    // exchange scheme: every position against every later one
                    for (int i = 0; i < fill; i++)
                        for (int j = i + 1; j < fill; j++)
                            if (collected[i] > collected[j])
                            begin
                                swap_tmp = collected[i];
                                collected[i] = collected[j];
                                collected[j] = swap_tmp;
                            end
                    for (int k = 0; k < fill; k++)
                    begin
                        want.value = collected[k];
                        want.last = (k == fill - 1);
                        want.ovf = dropped;
                        ascending_q.push_back(want);
                    end
                    fill = 0;
                    dropped = 1'b0;
                end
            end
            outstanding <= ascending_q.size();
        end
    end

endmodule

FILE: tb/tb_exchange_sort_engine.sv
// testbench top for the exchange sort engine: clock, reset, element stimulus and verdict
module tb_exchange_sort_engine import es_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH          = 64;
    localparam int          HALF_PERIOD    = 4;
    localparam int          RESET_CYCLES   = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          HOLD_AFTER     = 110;
    localparam int          RANDOM_ITEMS   = 200;
    localparam int          SETTLE_CYCLES  = 100;
    localparam int          WATCHDOG_LIMIT = 20000;

    localparam value_t MOST_NEG = value_t'(32'h8000_0000);
    localparam value_t MOST_POS = value_t'(32'h7fff_ffff);

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   results_seen;
    int   idle_cycles;
    int   burst_left;
    bit   offering;

    es_in_if  elements_ch ();
    es_out_if sorted_ch ();

    exchange_sort_engine #(
        .MAX_ELEMENTS (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .elements (elements_ch),
        .sorted   (sorted_ch)
    );

    es_sort_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .elements    (elements_ch),
        .sorted      (sorted_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (sorted_ch.valid && sorted_ch.ready)
            results_seen <= results_seen + 1;
        if (!rst_n || (elements_ch.valid && elements_ch.ready) ||
            (sorted_ch.valid && sorted_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("exchange_sort_engine regression: fail");
            $finish;
        end
    end

    // result sink: stall pattern changes every span, with one long hold-off
    initial
    begin : result_sink
        int mode;
        int span;
        bit held;
        held = 1'b0;
        sorted_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && results_seen >= HOLD_AFTER)
                begin
                    held = 1'b1;
                    sorted_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0: sorted_ch.ready <= 1'b1;
                    1: sorted_ch.ready <= 1'($urandom_range(0, 1));
                    2: sorted_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: sorted_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return value_t'($urandom());
            5, 6, 7: return value_t'(int'($urandom_range(0, 6)) - 3);
            default:
                case ($urandom_range(0, 4))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return value_t'(0);
                    3: return value_t'(-1);
                    default: return value_t'(1);
                endcase
        endcase
    endfunction

    task automatic offer_element(input value_t v, input logic is_last);
        int gap;
        elements_ch.valid <= 1'b1;
        elements_ch.value_in <= v;
        elements_ch.last_in <= is_last;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!elements_ch.ready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 48)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                elements_ch.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic offer_set(input value_t vals [$]);
        foreach (vals[k])
            offer_element(vals[k], k == vals.size() - 1);
    endtask

    task automatic await_drain();
        if (offering)
        begin
            elements_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin : element_source
        value_t vals [$];
        int     set_no;
        int     set_len;
        int     random_items;
        rst_n <= 1'b0;
        elements_ch.valid <= 1'b0;
        elements_ch.value_in <= '0;
        elements_ch.last_in <= 1'b0;
        offering = 1'b0;
        burst_left = 3;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element sets, extremes, duplicates, sorted and reversed input
        offer_set('{MOST_POS});
        offer_set('{MOST_NEG});
        offer_set('{3, -1, 3, MOST_NEG, MOST_POS, 0, -1, MOST_NEG});
        offer_set('{-2, -1, 0, 1, 2});
        offer_set('{5, 4, 3, 2, 1, 0});
        await_drain();

        set_no = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            if (set_no == 2)
                set_len = DEPTH + 3;
            if (set_no == 7)
                set_len = DEPTH;
            vals.delete();
            repeat (set_len)
                vals.push_back(pick_value());
            offer_set(vals);
            random_items += set_len;
            if (set_no == 4 || $urandom_range(0, 11) == 0)
                await_drain();
            set_no++;
        end

        await_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (outstanding != 0)
            $display("%0d expected sorted beats never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("exchange_sort_engine regression: pass");
        else
            $display("exchange_sort_engine regression: fail");
        $finish;
    end

endmodule
